FILE: design/yuv420_to_rgb888_pair_converter_defines.svh
// ----------------------------------------------------------------------------
// YUV 4:2:0 to RGB888 pair converter assertion macros
// Concurrent checks clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef YUV420_TO_RGB888_PAIR_CONVERTER_DEFINES_SVH
`define YUV420_TO_RGB888_PAIR_CONVERTER_DEFINES_SVH

// cond implies outcome in the same cycle
`define YRGB_ASSERT_SAME(label, cond, outcome, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (outcome)) \
		else $error(msg);

// cond implies outcome in the next cycle
`define YRGB_ASSERT_NEXT(label, cond, outcome, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (outcome)) \
		else $error(msg);

`endif

FILE: design/yrgb_pkg.sv
// ----------------------------------------------------------------------------
// YUV to RGB pair converter package
// Payload types, matrix codes and fixed-point coefficient tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package yrgb_pkg;

	localparam int YRGB_COEFF_FRAC_BITS = 12;

	localparam int YRGB_MATRIX_COUNT = 3;
	localparam int YRGB_MATRIX_IDX_W = $clog2(YRGB_MATRIX_COUNT);

	typedef enum logic [1:0] {
		YRGB_MATRIX_JPEG      = 2'd0,
		YRGB_MATRIX_SMPTE170M = 2'd1,
		YRGB_MATRIX_REC709    = 2'd2
	} yrgb_matrix_t;

	localparam int YRGB_COEF_Y     = 0;
	localparam int YRGB_COEF_VR    = 1;
	localparam int YRGB_COEF_UG    = 2;
	localparam int YRGB_COEF_VG    = 3;
	localparam int YRGB_COEF_UB    = 4;
	localparam int YRGB_COEF_COUNT = 5;

	// thousandths: y, vr, ug, vg, ub
	localparam int YRGB_COEF_MILLI [YRGB_MATRIX_COUNT][YRGB_COEF_COUNT] = '{
		'{1000, 1402, -344, -714, 1772},
		'{1164, 1596, -392, -813, 2017},
		'{1164, 1793, -213, -533, 2112}
	};

	localparam int YRGB_LUMA_OFFSET [YRGB_MATRIX_COUNT] = '{0, 16, 16};

	typedef struct packed {
		logic [7:0] luma_first;
		logic [7:0] luma_second;
		logic [7:0] chroma_blue;
		logic [7:0] chroma_red;
	} yrgb_yuv_t;

	typedef struct packed {
		logic [7:0] red_first;
		logic [7:0] green_first;
		logic [7:0] blue_first;
		logic [7:0] red_second;
		logic [7:0] green_second;
		logic [7:0] blue_second;
	} yrgb_rgb_t;

	// round to nearest, ties away from zero
	function automatic int yrgb_to_fixed(input int milli, input int frac_bits);
		longint mag;
		longint q;
		mag = (milli < 0) ? -longint'(milli) : longint'(milli);
		q = (mag * (longint'(1) << frac_bits) + 500) / 1000;
		return (milli < 0) ? -int'(q) : int'(q);
	endfunction

endpackage

`default_nettype wire

FILE: design/yrgb_stream_if.sv
// ----------------------------------------------------------------------------
// YUV to RGB pair converter stream interfaces
// Valid/ready channels for the YUV input and the RGB result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface yrgb_yuv_if import yrgb_pkg::*; ();
	logic      valid;
	logic      ready;
	yrgb_yuv_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface yrgb_rgb_if import yrgb_pkg::*; ();
	logic      valid;
	logic      ready;
	yrgb_rgb_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: design/yuv420_to_rgb888_pair_converter.sv
// ----------------------------------------------------------------------------
// YUV 4:2:0 to RGB888 pair converter
// Two luma samples and one shared Cb/Cr pair become two RGB888 pixels.
// ----------------------------------------------------------------------------
// Usage:
//   yuv  - valid/ready sink; one transfer carries two luma samples and the
//          chroma pair they share.
//   rgb  - valid/ready source; one transfer carries the two RGB888 pixels.
//   cfg_wr_en / cfg_wr_data - write matrix_select (0 JPEG full range,
//          1 SMPTE170M, 2 Rec709, 3 behaves as JPEG); write only while idle.
// Path: an input transfer is captured in the input register, then the
//   multiply, sum and clamp feed the result register that drives rgb.
// Throughput: one pixel pair per cycle while rgb is not held, set by the
//   two-stage pipeline; six coefficient multipliers work in parallel in one stage.
// Reset: arst_n clears both pipeline valids and sets the JPEG matrix.
// Stall: while rgb is held, the result register keeps its pixels, the input
//   register still fills, and yuv.ready drops once both stages are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "yuv420_to_rgb888_pair_converter_defines.svh"

module yuv420_to_rgb888_pair_converter
	import yrgb_pkg::*;
#(
	parameter int COEFF_FRAC_BITS = YRGB_COEFF_FRAC_BITS
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [1:0] cfg_wr_data,
	yrgb_yuv_if.sink        yuv,
	yrgb_rgb_if.source      rgb
);

	localparam int COEF_W = COEFF_FRAC_BITS + 3;
	localparam int SAMP_W = 9;
	localparam int PROD_W = COEF_W + SAMP_W;
	localparam int SUM_W  = PROD_W + 2;

	logic signed [COEF_W-1:0] coef_tab [YRGB_MATRIX_COUNT][YRGB_COEF_COUNT];
	logic        [7:0]        ofs_tab  [YRGB_MATRIX_COUNT];

	for (genvar m = 0; m < YRGB_MATRIX_COUNT; m++) begin : g_matrix
		for (genvar c = 0; c < YRGB_COEF_COUNT; c++) begin : g_coef
			assign coef_tab[m][c] = COEF_W'(yrgb_to_fixed(YRGB_COEF_MILLI[m][c],
				COEFF_FRAC_BITS));
		end
		assign ofs_tab[m] = 8'(YRGB_LUMA_OFFSET[m]);
	end

	logic [1:0]                   matrix_select_q;
	logic [YRGB_MATRIX_IDX_W-1:0] sel_idx;

	logic                         valid_s1;
	logic [YRGB_MATRIX_IDX_W-1:0] sel_s1;
	logic signed [SAMP_W-1:0]     y_first_s1;
	logic signed [SAMP_W-1:0]     y_second_s1;
	logic signed [SAMP_W-1:0]     cb_s1;
	logic signed [SAMP_W-1:0]     cr_s1;

	logic                         valid_s2;
	yrgb_rgb_t                    rgb_s2;

	logic                         adv_s2;
	logic                         yuv_xfer;

	logic signed [PROD_W-1:0]     p_y_first;
	logic signed [PROD_W-1:0]     p_y_second;
	logic signed [PROD_W-1:0]     p_vr;
	logic signed [PROD_W-1:0]     p_ug;
	logic signed [PROD_W-1:0]     p_vg;
	logic signed [PROD_W-1:0]     p_ub;
	logic signed [SUM_W-1:0]      part_r;
	logic signed [SUM_W-1:0]      part_g;
	logic signed [SUM_W-1:0]      part_b;
	logic signed [SUM_W-1:0]      base_first;
	logic signed [SUM_W-1:0]      base_second;
	yrgb_rgb_t                    rgb_next;

	function automatic logic [7:0] clamp_channel(input logic signed [SUM_W-1:0] sum);
		logic [SUM_W-1:0] mag;
		mag = sum;
		if (sum[SUM_W-1]) begin
			return 8'h00;
		end else if (|mag[SUM_W-1:COEFF_FRAC_BITS+8]) begin
			return 8'hFF;
		end else begin
			return mag[COEFF_FRAC_BITS+7:COEFF_FRAC_BITS];
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_select_q <= YRGB_MATRIX_JPEG;
		end else if (cfg_wr_en) begin
			matrix_select_q <= cfg_wr_data;
		end
	end

	always_comb begin
		case (matrix_select_q)
			YRGB_MATRIX_JPEG:      sel_idx = YRGB_MATRIX_IDX_W'(0);
			YRGB_MATRIX_SMPTE170M: sel_idx = YRGB_MATRIX_IDX_W'(1);
			YRGB_MATRIX_REC709:    sel_idx = YRGB_MATRIX_IDX_W'(2);
			default:               sel_idx = YRGB_MATRIX_IDX_W'(0);
		endcase
	end

	assign adv_s2    = !valid_s2 || rgb.ready;
	assign yuv.ready = !valid_s1 || adv_s2;
	assign yuv_xfer  = yuv.valid && yuv.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (yuv.ready) begin
			valid_s1 <= yuv.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (yuv_xfer) begin
			sel_s1      <= sel_idx;
			y_first_s1  <= $signed({1'b0, yuv.data.luma_first} - {1'b0, ofs_tab[sel_idx]});
			y_second_s1 <= $signed({1'b0, yuv.data.luma_second} - {1'b0, ofs_tab[sel_idx]});
			cb_s1       <= $signed({~yuv.data.chroma_blue[7], ~yuv.data.chroma_blue[7],
				yuv.data.chroma_blue[6:0]});
			cr_s1       <= $signed({~yuv.data.chroma_red[7], ~yuv.data.chroma_red[7],
				yuv.data.chroma_red[6:0]});
		end
	end

	always_comb begin
		p_y_first   = PROD_W'(coef_tab[sel_s1][YRGB_COEF_Y]) * PROD_W'(y_first_s1);
		p_y_second  = PROD_W'(coef_tab[sel_s1][YRGB_COEF_Y]) * PROD_W'(y_second_s1);
		p_vr        = PROD_W'(coef_tab[sel_s1][YRGB_COEF_VR]) * PROD_W'(cr_s1);
		p_ug        = PROD_W'(coef_tab[sel_s1][YRGB_COEF_UG]) * PROD_W'(cb_s1);
		p_vg        = PROD_W'(coef_tab[sel_s1][YRGB_COEF_VG]) * PROD_W'(cr_s1);
		p_ub        = PROD_W'(coef_tab[sel_s1][YRGB_COEF_UB]) * PROD_W'(cb_s1);
		base_first  = SUM_W'(p_y_first);
		base_second = SUM_W'(p_y_second);
		part_r      = SUM_W'(p_vr);
		part_g      = SUM_W'(p_ug) + SUM_W'(p_vg);
		part_b      = SUM_W'(p_ub);

		rgb_next.red_first    = clamp_channel(base_first + part_r);
		rgb_next.green_first  = clamp_channel(base_first + part_g);
		rgb_next.blue_first   = clamp_channel(base_first + part_b);
		rgb_next.red_second   = clamp_channel(base_second + part_r);
		rgb_next.green_second = clamp_channel(base_second + part_g);
		rgb_next.blue_second  = clamp_channel(base_second + part_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			rgb_s2 <= rgb_next;
		end
	end

	assign rgb.valid = valid_s2;
	assign rgb.data  = rgb_s2;

	`YRGB_ASSERT_NEXT(a_input_fills_s1, yuv_xfer, valid_s1, "input transfer lost before s1")
	`YRGB_ASSERT_NEXT(a_s1_moves_to_s2, valid_s1 && adv_s2, rgb.valid, "s1 item not advanced")
	`YRGB_ASSERT_SAME(a_full_blocks_input, rgb.valid && !rgb.ready && valid_s1, !yuv.ready,
		"input accepted with both stages held")

endmodule

`default_nettype wire

FILE: dv/tb_yuv420_to_rgb888_pair_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YUV 4:2:0 to RGB888 pair converter testbench
// Drives luma pairs with shared chroma through every colour matrix setting,
// with random gaps on both sides, and compares each RGB pair transfer against
// a fixed-point prediction of the two pixels.
// ----------------------------------------------------------------------------

module tb_yuv420_to_rgb888_pair_converter;
	import yrgb_pkg::*;

	localparam logic [1:0] MATRIX_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 2000;
	localparam int PHASE_PAIRS = 125;

	class rgb_pair_checker;
		logic [1:0] matrix_sel;
		yrgb_rgb_t expected_pixels[$];
		int errors;

		function new();
			matrix_sel = YRGB_MATRIX_JPEG;
			errors = 0;
		endfunction

		function logic [7:0] clamp_channel(int sum);
			int whole;
			if (sum < 0)
				return 8'd0;
			whole = sum >>> YRGB_COEFF_FRAC_BITS;
			if (whole > 255)
				return 8'd255;
			return whole[7:0];
		endfunction

		function yrgb_rgb_t predict_rgb_pair(yrgb_yuv_t px);
			yrgb_rgb_t res;
			int cy, cvr, cug, cvg, cub, offset;
			int y0, y1, u, v, red_part, green_part, blue_part;
			// coefficients with 12 fraction bits, rounded to nearest
			case (yrgb_matrix_t'(matrix_sel))
				YRGB_MATRIX_SMPTE170M: begin
					cy = 4768; cvr = 6537; cug = -1606; cvg = -3330; cub = 8262;
					offset = 16;
				end
				YRGB_MATRIX_REC709: begin
					cy = 4768; cvr = 7344; cug = -872; cvg = -2183; cub = 8651;
					offset = 16;
				end
				default: begin
					cy = 4096; cvr = 5743; cug = -1409; cvg = -2925; cub = 7258;
					offset = 0;
				end
			endcase
			y0 = int'(px.luma_first) - offset;
			y1 = int'(px.luma_second) - offset;
			u = int'(px.chroma_blue) - 128;
			v = int'(px.chroma_red) - 128;
			red_part = cvr * v;
			green_part = cug * u + cvg * v;
			blue_part = cub * u;
			res.red_first = clamp_channel(cy * y0 + red_part);
			res.green_first = clamp_channel(cy * y0 + green_part);
			res.blue_first = clamp_channel(cy * y0 + blue_part);
			res.red_second = clamp_channel(cy * y1 + red_part);
			res.green_second = clamp_channel(cy * y1 + green_part);
			res.blue_second = clamp_channel(cy * y1 + blue_part);
			return res;
		endfunction

		function void note_yuv_pair(yrgb_yuv_t px);
			expected_pixels.push_back(predict_rgb_pair(px));
		endfunction

		function void compare_channel(string name, logic [7:0] want, logic [7:0] got);
			if (want !== got) begin
				$display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_rgb_pair(yrgb_rgb_t got);
			yrgb_rgb_t want;
			if (expected_pixels.size() == 0) begin
				$display("%0t: rgb transfer with nothing expected, actual %h", $time, got);
				errors++;
				return;
			end
			want = expected_pixels.pop_front();
			compare_channel("red_first", want.red_first, got.red_first);
			compare_channel("green_first", want.green_first, got.green_first);
			compare_channel("blue_first", want.blue_first, got.blue_first);
			compare_channel("red_second", want.red_second, got.red_second);
			compare_channel("green_second", want.green_second, got.green_second);
			compare_channel("blue_second", want.blue_second, got.blue_second);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [1:0] cfg_wr_data;

	yrgb_yuv_if yuv_ch();
	yrgb_rgb_if rgb_ch();

	rgb_pair_checker pixel_check = new();

	int tx_calm_left;
	int rx_calm_left;
	int rx_stall_left;
	int idle_cycles;

	yuv420_to_rgb888_pair_converter dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.yuv(yuv_ch),
		.rgb(rgb_ch)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic int pick_gap();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] pick_sample();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return 8'd0;
		if (r < 16)
			return 8'd255;
		if (r < 24)
			return 8'($urandom_range(125, 131));
		if (r < 30)
			return 8'($urandom_range(10, 20));
		return 8'($urandom);
	endfunction

	task automatic send_yuv_pair(input yrgb_yuv_t px);
		yuv_ch.valid <= 1'b1;
		yuv_ch.data <= px;
		@(posedge clk);
		while (!yuv_ch.ready)
			@(posedge clk);
		pixel_check.note_yuv_pair(px);
		if (tx_calm_left > 0) begin
			tx_calm_left--;
		end else if ($urandom_range(0, 99) < 30) begin
			yuv_ch.valid <= 1'b0;
			repeat (pick_gap()) @(posedge clk);
		end else if ($urandom_range(0, 99) < 3) begin
			tx_calm_left = $urandom_range(20, 80);
		end
	endtask

	task automatic wait_drained();
		yuv_ch.valid <= 1'b0;
		@(posedge clk);
		while (pixel_check.expected_pixels.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_matrix(input logic [1:0] sel);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= sel;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		pixel_check.matrix_sel = sel;
		@(posedge clk);
	endtask

	task automatic send_directed();
		send_yuv_pair('{8'd0, 8'd255, 8'd0, 8'd0});
		send_yuv_pair('{8'd255, 8'd0, 8'd255, 8'd255});
		send_yuv_pair('{8'd16, 8'd235, 8'd128, 8'd128});
		send_yuv_pair('{8'd255, 8'd255, 8'd0, 8'd255});
		send_yuv_pair('{8'd0, 8'd0, 8'd255, 8'd0});
		send_yuv_pair('{8'd128, 8'd127, 8'd240, 8'd16});
	endtask

	task automatic send_random(input int count, input bit hold_mid);
		yrgb_yuv_t px;
		for (int i = 0; i < count; i++) begin
			px.luma_first = pick_sample();
			px.luma_second = pick_sample();
			px.chroma_blue = pick_sample();
			px.chroma_red = pick_sample();
			send_yuv_pair(px);
			if (hold_mid && i == count / 2)
				wait_drained();
		end
	endtask

	// source side
	initial begin
		logic [1:0] directed_sel[4];
		logic [1:0] random_sel[8];
		directed_sel = '{YRGB_MATRIX_JPEG, YRGB_MATRIX_SMPTE170M, YRGB_MATRIX_REC709,
			MATRIX_UNUSED};
		random_sel = '{YRGB_MATRIX_SMPTE170M, MATRIX_UNUSED, YRGB_MATRIX_REC709,
			YRGB_MATRIX_JPEG, YRGB_MATRIX_REC709, YRGB_MATRIX_SMPTE170M,
			YRGB_MATRIX_JPEG, MATRIX_UNUSED};
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 2'd0;
		yuv_ch.valid = 1'b0;
		yuv_ch.data = '0;
		tx_calm_left = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_sel[k]) begin
			write_matrix(directed_sel[k]);
			send_directed();
		end
		foreach (random_sel[k]) begin
			write_matrix(random_sel[k]);
			send_random(PHASE_PAIRS, k == 2);
		end
		wait_drained();
		repeat (10) @(posedge clk);
		if (pixel_check.errors == 0 && pixel_check.expected_pixels.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// sink side
	initial begin
		rgb_ch.ready = 1'b0;
		rx_calm_left = 0;
		rx_stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && rgb_ch.valid && rgb_ch.ready)
				pixel_check.check_rgb_pair(rgb_ch.data);
			if (rx_stall_left > 0) begin
				rx_stall_left--;
				rgb_ch.ready <= 1'b0;
			end else begin
				rgb_ch.ready <= 1'b1;
				if (rx_calm_left > 0)
					rx_calm_left--;
				else if ($urandom_range(0, 99) < 25)
					rx_stall_left = pick_gap();
				else if ($urandom_range(0, 99) < 3)
					rx_calm_left = $urandom_range(20, 80);
			end
		end
	end

	// watchdog
	initial idle_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((yuv_ch.valid && yuv_ch.ready) || (rgb_ch.valid && rgb_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

endmodule
